>>> rtl/dematc_pkg.sv
// shared constants and types for the debounced ema temperature classifier
`default_nettype none

package dematc_pkg;

  // fraction bits of the filter state and width of the debounce run counter
  localparam int FracBits  = 8;
  localparam int CountBits = 16;

  // field widths
  localparam int SampleW = 12;
  localparam int AlphaW  = 9;
  localparam int DebW    = 16;
  localparam int DutyW   = 16;
  localparam int CfgW    = 16;
  localparam int CfgIdxW = 2;

  // derived widths
  localparam int FiltW  = SampleW + FracBits;
  localparam int AccW   = FiltW + AlphaW + 1;
  localparam int ProdW  = AlphaW + SampleW;
  localparam int CmpW   = (CountBits > DebW) ? CountBits : DebW;

  // q8 smoothing weight
  localparam int AlphaShift = 8;
  localparam int AlphaOne   = 1 << AlphaShift;
  localparam int AlphaHalf  = AlphaOne / 2;

  // servo duty words: pulse of 500..2400 us over 0..180 degrees in a 20 ms period
  localparam int PulseLo  = 500;
  localparam int PulseHi  = 2400;
  localparam int PeriodUs = 20000;
  localparam int DutyFull = 65535;
  localparam int Duty135  = (PulseLo + 135 * (PulseHi - PulseLo) / 180) * DutyFull / PeriodUs;
  localparam int Duty90   = (PulseLo + 90 * (PulseHi - PulseLo) / 180) * DutyFull / PeriodUs;
  localparam int Duty45   = (PulseLo + 45 * (PulseHi - PulseLo) / 180) * DutyFull / PeriodUs;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_SMOOTHING = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_LOW_LIMIT = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_HIGH_LIMIT = 2'd3;

  // lamp codes, one hot: green, yellow, red
  typedef logic [2:0] lamp_t;
  localparam lamp_t LAMP_OFF    = 3'b000;
  localparam lamp_t LAMP_GREEN  = 3'b001;
  localparam lamp_t LAMP_YELLOW = 3'b010;
  localparam lamp_t LAMP_RED    = 3'b100;

  // register reset values
  localparam logic [AlphaW-1:0]  SMOOTHING_RST = 9'd77;
  localparam logic [DebW-1:0]    DEBOUNCE_RST  = 16'd50;
  localparam logic [SampleW-1:0] LOW_RST       = 12'd220;
  localparam logic [SampleW-1:0] HIGH_RST      = 12'd250;

endpackage

`default_nettype wire

>>> rtl/debounced_ema_temperature_classifier_core.sv
// top level: debounce, ema filter and three band classifier on millisecond ticks
`default_nettype none

// channel   direction  handshake                    payload
// ------------------------------------------------------------------------------------
// tick in   input      in_valid_i / in_ready_o      button_level_i, sample_mv_i
// result    output     out_valid_o / out_ready_i    green_on_o, yellow_on_o, red_on_o,
//                                                   servo_duty_o, temp_tenths_o,
//                                                   new_reading_o
// config    input      cfg_we_i (no wait)           cfg_index_i, cfg_data_i
//
// one tick per cycle sustained while results are taken; a tick is held in the input
// register, then its result is loaded into and read from the state registers themselves
// the state update and result load happen together, so a stalled result holds the
// state and the input register buffers one more tick while out_ready_i is low
// the critical path is the two filter multiplies feeding one add and compare
// rst_ni clears the pipeline valids and loads the state and config reset values

module debounced_ema_temperature_classifier_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic                              button_level_i,
  input  wire logic [dematc_pkg::SampleW-1:0]    sample_mv_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic                                   green_on_o,
  output logic                                   yellow_on_o,
  output logic                                   red_on_o,
  output logic [dematc_pkg::DutyW-1:0]           servo_duty_o,
  output logic [dematc_pkg::SampleW-1:0]         temp_tenths_o,
  output logic                                   new_reading_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [dematc_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  wire logic [dematc_pkg::CfgW-1:0]       cfg_data_i
);

  localparam int FiltW  = dematc_pkg::FiltW;
  localparam int AccW   = dematc_pkg::AccW;
  localparam int ProdW  = dematc_pkg::ProdW;
  localparam int CntW   = dematc_pkg::CountBits;
  localparam int CmpW   = dematc_pkg::CmpW;
  localparam int Frac   = dematc_pkg::FracBits;
  localparam int AlphaW = dematc_pkg::AlphaW;
  localparam int SampW  = dematc_pkg::SampleW;

  // configuration registers
  logic [AlphaW-1:0]          smoothing_q;
  logic [dematc_pkg::DebW-1:0] debounce_q;
  logic [SampW-1:0]           low_limit_q;
  logic [SampW-1:0]           high_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smoothing_q  <= dematc_pkg::SMOOTHING_RST;
      debounce_q   <= dematc_pkg::DEBOUNCE_RST;
      low_limit_q  <= dematc_pkg::LOW_RST;
      high_limit_q <= dematc_pkg::HIGH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        dematc_pkg::CFG_SMOOTHING:  smoothing_q  <= cfg_data_i[AlphaW-1:0];
        dematc_pkg::CFG_DEBOUNCE:   debounce_q   <= cfg_data_i[dematc_pkg::DebW-1:0];
        dematc_pkg::CFG_LOW_LIMIT:  low_limit_q  <= cfg_data_i[SampW-1:0];
        dematc_pkg::CFG_HIGH_LIMIT: high_limit_q <= cfg_data_i[SampW-1:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic             s1_valid_q;
  logic             s1_level_q;
  logic [SampW-1:0] s1_sample_q;
  logic             advance;
  logic             out_valid_q;

  // a tick moves on when the result slot is empty or being taken
  assign advance    = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_level_q  <= button_level_i;
      s1_sample_q <= sample_mv_i;
    end
  end

  // state registers, loaded together with the result slot
  logic [FiltW-1:0]            filt_q, filt_d;
  logic [CntW-1:0]             count_q, count_d;
  logic                        prev_level_q;
  logic                        acc_level_q;
  dematc_pkg::lamp_t           lamp_q, lamp_d;
  logic [dematc_pkg::DutyW-1:0] servo_q, servo_d;
  logic                        took_q, took_d;

  // debounce run counter, saturating
  always_comb begin
    if (s1_level_q != prev_level_q) begin
      count_d = '0;
    end else if (count_q != {CntW{1'b1}}) begin
      count_d = count_q + CntW'(1);
    end else begin
      count_d = count_q;
    end
  end

  assign took_d = (CmpW'(count_d) > CmpW'(debounce_q)) && (s1_level_q != acc_level_q)
                  && !s1_level_q;

  // ema filter: (a * sample<<frac + (256 - a) * old + 128) >> 8
  logic [AlphaW-1:0] alpha_eff;
  logic [AlphaW-1:0] alpha_rest;
  logic [ProdW-1:0]  new_part;
  logic [AccW-1:0]   acc_sum;
  logic [FiltW-1:0]  filt_new;

  assign alpha_eff  = smoothing_q[AlphaW-1] ? AlphaW'(dematc_pkg::AlphaOne) : smoothing_q;
  assign alpha_rest = AlphaW'(dematc_pkg::AlphaOne) - alpha_eff;
  assign new_part   = ProdW'(alpha_eff) * ProdW'(s1_sample_q);
  assign acc_sum    = (AccW'(new_part) << Frac)
                    + AccW'(alpha_rest) * AccW'(filt_q)
                    + AccW'(dematc_pkg::AlphaHalf);
  // result stays below 4096 << frac, so the top bits are zero
  assign filt_new   = acc_sum[FiltW+dematc_pkg::AlphaShift-1:dematc_pkg::AlphaShift];

  // classify against the limits, low first
  always_comb begin
    filt_d  = filt_q;
    lamp_d  = lamp_q;
    servo_d = servo_q;
    if (took_d) begin
      filt_d = filt_new;
      if (filt_new < (FiltW'(low_limit_q) << Frac)) begin
        lamp_d  = dematc_pkg::LAMP_GREEN;
        servo_d = dematc_pkg::DutyW'(dematc_pkg::Duty135);
      end else if (filt_new < (FiltW'(high_limit_q) << Frac)) begin
        lamp_d  = dematc_pkg::LAMP_YELLOW;
        servo_d = dematc_pkg::DutyW'(dematc_pkg::Duty90);
      end else begin
        lamp_d  = dematc_pkg::LAMP_RED;
        servo_d = dematc_pkg::DutyW'(dematc_pkg::Duty45);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_q       <= '0;
      count_q      <= '0;
      prev_level_q <= 1'b1;
      acc_level_q  <= 1'b1;
      lamp_q       <= dematc_pkg::LAMP_OFF;
      servo_q      <= dematc_pkg::DutyW'(dematc_pkg::Duty90);
      took_q       <= 1'b0;
    end else if (advance) begin
      filt_q       <= filt_d;
      count_q      <= count_d;
      prev_level_q <= s1_level_q;
      // the accepted level only moves once the run is long enough
      if ((CmpW'(count_d) > CmpW'(debounce_q)) && (s1_level_q != acc_level_q)) begin
        acc_level_q <= s1_level_q;
      end
      lamp_q       <= lamp_d;
      servo_q      <= servo_d;
      took_q       <= took_d;
    end
  end

  // result slot valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // result fields come straight from the state, which only moves with the slot
  assign out_valid_o   = out_valid_q;
  assign green_on_o    = lamp_q[0];
  assign yellow_on_o   = lamp_q[1];
  assign red_on_o      = lamp_q[2];
  assign servo_duty_o  = servo_q;
  assign temp_tenths_o = filt_q[FiltW-1:Frac];
  assign new_reading_o = took_q;

endmodule

`default_nettype wire
